/* rtl/tcw_pkg.sv */
// Shared types and constants of the text console writer.
// Request, result and internal command types, action and state codes.
// Depends on nothing.
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int COL_OUT_W  = 7;
  localparam int ROW_OUT_W  = 5;
  localparam int CMD_ADDR_W = 13;
  localparam int CELL_W     = 16;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [7:0] RESET_ATTR = 8'h0a;
  localparam logic [7:0] BLANK_ATTR = 8'h00;
  localparam logic [7:0] FILL_CHAR  = 8'h58;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_INIT  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } tcw_action_t;

  typedef enum logic [1:0] {
    ST_WIPE,
    ST_RUN,
    ST_SCROLL,
    ST_CLEAR
  } tcw_state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic [6:0] cell_col;
    logic [4:0] cell_row;
  } tcw_request_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [CELL_W-1:0]    cell_value;
  } tcw_result_t;

  typedef struct packed {
    tcw_action_t           action;
    logic [7:0]            char_code;
    logic                  read_ok;
    logic [CMD_ADDR_W-1:0] read_addr;
  } tcw_cmd_t;

endpackage

/* rtl/tcw_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on tcw_pkg for default sizes.
module tcw_ram import tcw_pkg::*; #(
  parameter int WIDTH = CELL_W,
  parameter int DEPTH = DEF_COLUMNS * DEF_ROWS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tcw_front.sv */
// Front end: accepts requests and turns them into queued commands.
// Depends on tcw_pkg; feeds tcw_queue.
module tcw_front import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic         start,
  input  tcw_request_t request,
  input  logic         full,
  input  logic         wiping,
  output logic         busy,
  output logic         push,
  output tcw_cmd_t     cmd
);

  localparam logic [CMD_ADDR_W-1:0] COLS_A = CMD_ADDR_W'(COLUMNS);

  assign busy = full | wiping;
  assign push = start & ~busy;

  always_comb begin
    cmd.action    = tcw_action_t'(request.action);
    cmd.char_code = request.char_code;
    cmd.read_ok   = (32'(request.cell_col) < COLUMNS) && (32'(request.cell_row) < ROWS);
    cmd.read_addr = CMD_ADDR_W'(request.cell_row) * COLS_A + CMD_ADDR_W'(request.cell_col);
  end

endmodule

/* rtl/tcw_queue.sv */
// Two-entry command queue between the front end and the back end.
// Depends on tcw_pkg.
module tcw_queue import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  tcw_cmd_t din,
  input  logic     pop,
  output tcw_cmd_t dout,
  output logic     full,
  output logic     empty
);

  tcw_cmd_t          entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign dout  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/tcw_back.sv */
// Back end: executes commands against the screen RAM, keeps the cursor,
// runs the wipe, scroll fill and clear sweeps. Depends on tcw_pkg, tcw_ram.
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  attr,
  input  tcw_cmd_t    head,
  input  logic        head_valid,
  output logic        pop,
  output logic        wiping,
  output logic        done,
  output tcw_result_t result
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [AW-1:0] A_LAST      = AW'(CELLS - 1);
  localparam logic [AW-1:0] A_LAST_ROW  = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] A_COLS      = AW'(COLUMNS);
  localparam logic [AW-1:0] A_WRAP_BASE = AW'(CELLS - COLUMNS);
  localparam logic [AW:0]   CELLS_X     = (AW+1)'(CELLS);
  localparam logic [CW-1:0] C_LAST      = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] R_LAST      = RW'(ROWS - 1);

  tcw_state_t state, state_next;

  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic [AW-1:0] cur_addr, cur_addr_next;
  logic [AW-1:0] base_lin, base_lin_next;
  logic [AW-1:0] sweep, sweep_next;
  logic [AW-1:0] limit, limit_next;
  logic [CW-1:0] fcnt, fcnt_next;

  logic                 res_fire;
  logic                 res_read;
  logic                 rd_flag;
  logic [COL_OUT_W-1:0] res_col;
  logic [ROW_OUT_W-1:0] res_row;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [CELL_W-1:0] rdata;

  logic [AW:0]   sum_addr;
  logic [AW-1:0] cur_inc;
  logic [AW-1:0] sweep_inc;
  logic [CW-1:0] c_eff;

  assign wiping = (state == ST_WIPE);

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sum_addr  = {1'b0, head.read_addr[AW-1:0]} + {1'b0, base_lin};
    raddr     = (sum_addr >= CELLS_X) ? AW'(sum_addr - CELLS_X) : sum_addr[AW-1:0];
    cur_inc   = (cur_addr == A_LAST) ? '0 : cur_addr + 1'b1;
    sweep_inc = (sweep == A_LAST) ? '0 : sweep + 1'b1;
    c_eff     = (head.action == ACT_INIT) ? '0 : col;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_WIPE: begin
        if (sweep == A_LAST) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (head_valid) begin
          unique case (head.action)
            ACT_PUT: begin
              if (col == C_LAST && row == R_LAST) state_next = ST_SCROLL;
            end
            ACT_INIT, ACT_CLEAR: state_next = ST_CLEAR;
            ACT_READ: state_next = ST_RUN;
          endcase
        end
      end
      ST_SCROLL: begin
        if (fcnt == C_LAST) state_next = ST_RUN;
      end
      ST_CLEAR: begin
        if (sweep == A_LAST) state_next = ST_RUN;
      end
    endcase
  end

  always_comb begin
    we            = 1'b0;
    waddr         = cur_addr;
    wdata         = '0;
    pop           = 1'b0;
    res_fire      = 1'b0;
    res_read      = 1'b0;
    col_next      = col;
    row_next      = row;
    cur_addr_next = cur_addr;
    base_lin_next = base_lin;
    sweep_next    = sweep;
    limit_next    = limit;
    fcnt_next     = fcnt;
    unique case (state)
      ST_WIPE: begin
        we         = 1'b1;
        waddr      = sweep;
        wdata      = '0;
        sweep_next = sweep_inc;
      end
      ST_RUN: begin
        if (head_valid) begin
          pop      = 1'b1;
          res_fire = 1'b1;
          unique case (head.action)
            ACT_PUT: begin
              we            = 1'b1;
              waddr         = cur_addr;
              wdata         = {attr, head.char_code};
              cur_addr_next = cur_inc;
              if (col == C_LAST) begin
                col_next = '0;
                if (row == R_LAST) begin
                  fcnt_next = '0;
                end else begin
                  row_next = row + 1'b1;
                end
              end else begin
                col_next = col + 1'b1;
              end
            end
            ACT_INIT, ACT_CLEAR: begin
              col_next      = c_eff;
              row_next      = R_LAST;
              limit_next    = A_LAST_ROW + AW'(c_eff);
              cur_addr_next = A_LAST_ROW + AW'(c_eff);
              base_lin_next = '0;
              sweep_next    = '0;
            end
            ACT_READ: begin
              res_read = head.read_ok;
            end
          endcase
        end
      end
      ST_SCROLL: begin
        we        = 1'b1;
        waddr     = cur_addr + AW'(fcnt);
        wdata     = {attr, SPACE_CHAR};
        fcnt_next = fcnt + 1'b1;
        if (fcnt == C_LAST) begin
          base_lin_next = (base_lin == A_WRAP_BASE) ? '0 : base_lin + A_COLS;
        end
      end
      ST_CLEAR: begin
        we         = 1'b1;
        waddr      = sweep;
        wdata      = (sweep < limit) ? {BLANK_ATTR, FILL_CHAR} : {attr, SPACE_CHAR};
        sweep_next = sweep_inc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_WIPE;
      col      <= '0;
      row      <= '0;
      cur_addr <= '0;
      base_lin <= '0;
      sweep    <= '0;
      limit    <= '0;
      fcnt     <= '0;
      done     <= 1'b0;
      rd_flag  <= 1'b0;
    end else begin
      state    <= state_next;
      col      <= col_next;
      row      <= row_next;
      cur_addr <= cur_addr_next;
      base_lin <= base_lin_next;
      sweep    <= sweep_next;
      limit    <= limit_next;
      fcnt     <= fcnt_next;
      done     <= res_fire;
      rd_flag  <= res_read;
    end
  end

  always_ff @(posedge clk) begin
    res_col <= COL_OUT_W'(col_next);
    res_row <= ROW_OUT_W'(row_next);
  end

  always_comb begin
    result.cursor_col = res_col;
    result.cursor_row = res_row;
    result.cell_value = rd_flag ? rdata : '0;
  end

endmodule

/* rtl/text_console_writer_top.sv */
// Top level of the text console writer: front end, command queue, back end
// and the text attribute register. Depends on tcw_pkg and all tcw_* modules.
//
// An item is taken when start is high and busy is low; up to two items queue
// ahead of the execution unit. Puts and reads run at one item per clock
// while no wipe, scroll fill or clear is running. Each result pulses done for
// one cycle: the accepted command is written into the queue, and done is
// registered as the back end pops it; the receiver must take it then. The
// screen RAM has one write port, which sets the long operations: a put that
// steps past the last row then fills the new bottom row cell by cell, and init
// or clear rewrites every cell. Scrolling moves a row base pointer, not data.
// After reset the RAM is wiped with busy high; the attribute port is always ready.
module text_console_writer_top import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  tcw_request_t request,
  output logic         done,
  output tcw_result_t  result,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data
);

  logic       attr;
  logic [7:0] text_attr;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  logic       wiping;
  tcw_cmd_t   cmd;
  tcw_cmd_t   head;

  assign cfg_ready = 1'b1;
  assign attr      = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= RESET_ATTR;
    end else if (attr) begin
      text_attr <= cfg_data;
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .start   (start),
    .request (request),
    .full    (full),
    .wiping  (wiping),
    .busy    (busy),
    .push    (push),
    .cmd     (cmd)
  );

  tcw_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd),
    .pop   (pop),
    .dout  (head),
    .full  (full),
    .empty (empty)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .attr       (text_attr),
    .head       (head),
    .head_valid (~empty),
    .pop        (pop),
    .wiping     (wiping),
    .done       (done),
    .result     (result)
  );

  a_no_result_in_wipe: assert property (@(posedge clk) disable iff (rst)
    wiping |-> !done)
    else $error("result during reset wipe");

  a_wipe_once: assert property (@(posedge clk) disable iff (rst)
    !$rose(wiping))
    else $error("wipe restarted outside reset");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(result.cursor_col) < COLUMNS))
    else $error("cursor column out of range");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty && !wiping)
    else $error("queue popped while empty or wiping");

endmodule
